### rtl/rgb_to_yuyv_422_converter_macros.svh
// Assertion macros for the RGB to YUYV 4:2:2 converter checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef RGB_TO_YUYV_422_CONVERTER_MACROS_SVH
`define RGB_TO_YUYV_422_CONVERTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define RYC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ryc checker: property failed");

// next-cycle implication, disabled in reset
`define RYC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ryc checker: property failed");

`endif

### rtl/ryc_pkg.sv
// Shared types and coefficients for the RGB to YUYV 4:2:2 converter.
// No dependencies.
package ryc_pkg;

    localparam int unsigned CompW = 8;
    localparam int unsigned AccW  = 16;

    localparam logic [AccW-1:0] KYR    = 16'd77;
    localparam logic [AccW-1:0] KYG    = 16'd150;
    localparam logic [AccW-1:0] KYB    = 16'd29;
    localparam logic [AccW-1:0] KUR    = 16'd43;   // subtracted
    localparam logic [AccW-1:0] KUG    = 16'd84;   // subtracted
    localparam logic [AccW-1:0] KUB    = 16'd127;
    localparam logic [AccW-1:0] KVR    = 16'd127;
    localparam logic [AccW-1:0] KVG    = 16'd106;  // subtracted
    localparam logic [AccW-1:0] KVB    = 16'd21;   // subtracted
    localparam logic [AccW-1:0] CBias  = 16'd32768; // 128 << 8

    typedef struct packed {
        logic [CompW-1:0] red;
        logic [CompW-1:0] green;
        logic [CompW-1:0] blue;
        logic             last_in_row;
    } t_in_word;

    typedef struct packed {
        logic [CompW-1:0] luma_first;
        logic [CompW-1:0] chroma_blue;
        logic [CompW-1:0] luma_second;
        logic [CompW-1:0] chroma_red;
    } t_out_word;

    typedef struct packed {
        logic [CompW-1:0] y;
        logic [CompW-1:0] u;
        logic [CompW-1:0] v;
    } t_yuv;

endpackage

### rtl/ryc_pix_calc.sv
// Per-pixel luma and chroma from one RGB24 pixel.
// Depends on ryc_pkg.
module ryc_pix_calc (
    input  ryc_pkg::t_in_word i_pix,
    output ryc_pkg::t_yuv     o_yuv
);

    logic [ryc_pkg::AccW-1:0] r;
    logic [ryc_pkg::AccW-1:0] g;
    logic [ryc_pkg::AccW-1:0] b;
    logic [ryc_pkg::AccW-1:0] y_acc;
    logic [ryc_pkg::AccW-1:0] u_acc;
    logic [ryc_pkg::AccW-1:0] v_acc;

    assign r = ryc_pkg::AccW'(i_pix.red);
    assign g = ryc_pkg::AccW'(i_pix.green);
    assign b = ryc_pkg::AccW'(i_pix.blue);

    // biased chroma stays in 0..65535, so modulo arithmetic is exact
    assign y_acc = ryc_pkg::KYR * r + ryc_pkg::KYG * g + ryc_pkg::KYB * b;
    assign u_acc = ryc_pkg::CBias + ryc_pkg::KUB * b - ryc_pkg::KUR * r - ryc_pkg::KUG * g;
    assign v_acc = ryc_pkg::CBias + ryc_pkg::KVR * r - ryc_pkg::KVG * g - ryc_pkg::KVB * b;

    assign o_yuv.y = y_acc[ryc_pkg::AccW-1 -: ryc_pkg::CompW];
    assign o_yuv.u = u_acc[ryc_pkg::AccW-1 -: ryc_pkg::CompW];
    assign o_yuv.v = v_acc[ryc_pkg::AccW-1 -: ryc_pkg::CompW];

endmodule

### rtl/ryc_pair.sv
// Pixel pairing: holds the first pixel of a pair and forms the YUYV word.
// Depends on ryc_pkg.
module ryc_pair (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ryc_pkg::t_yuv      i_yuv,
    input  logic               i_last,
    input  logic               i_take,
    output logic               o_emit,
    output ryc_pkg::t_out_word o_word
);

    logic          r_have;
    logic          n_have;
    ryc_pkg::t_yuv r_held;
    ryc_pkg::t_yuv n_held;
    ryc_pkg::t_yuv first;
    logic [ryc_pkg::CompW:0] u_sum;
    logic [ryc_pkg::CompW:0] v_sum;

    assign o_emit = r_have || i_last;
    assign first  = r_have ? r_held : i_yuv;
    assign u_sum  = {1'b0, first.u} + {1'b0, i_yuv.u};
    assign v_sum  = {1'b0, first.v} + {1'b0, i_yuv.v};

    always_comb begin
        o_word.luma_first  = first.y;
        o_word.chroma_blue = u_sum[ryc_pkg::CompW:1];
        o_word.luma_second = i_yuv.y;
        o_word.chroma_red  = v_sum[ryc_pkg::CompW:1];
    end

    always_comb begin
        n_have = r_have;
        n_held = r_held;
        if (i_take) begin
            if (r_have) begin
                n_have = 1'b0;
            end else if (!i_last) begin
                n_have = 1'b1;
                n_held = i_yuv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
        r_held <= n_held;
    end

endmodule

### rtl/rgb_to_yuyv_422_converter.sv
// RGB24 to YUYV 4:2:2 converter, top level.
// The pixel that closes a pair is held in the input register; its word is then loaded into the result register.
// Throughput: one pixel per cycle while the output is not stalled; one word per pair.
// Reset (synchronous, active low) empties both registers and drops any held pixel.
// Depends on ryc_pkg, ryc_pix_calc, ryc_pair.
module rgb_to_yuyv_422_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ryc_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ryc_pkg::t_out_word o_out_data
);

    logic               r_s1_valid;
    logic               n_s1_valid;
    ryc_pkg::t_in_word  r_s1_data;
    ryc_pkg::t_in_word  n_s1_data;
    logic               r_out_valid;
    logic               n_out_valid;
    ryc_pkg::t_out_word r_out_data;
    ryc_pkg::t_out_word n_out_data;

    ryc_pkg::t_yuv      pix_yuv;
    ryc_pkg::t_out_word pair_word;
    logic               emit;
    logic               out_free;
    logic               s1_take;

    ryc_pix_calc u_pix_calc (
        .i_pix (r_s1_data),
        .o_yuv (pix_yuv)
    );

    ryc_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_yuv   (pix_yuv),
        .i_last  (r_s1_data.last_in_row),
        .i_take  (s1_take),
        .o_emit  (emit),
        .o_word  (pair_word)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_take    = r_s1_valid && (!emit || out_free);
    assign o_in_ready = !r_s1_valid || s1_take;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_data   = r_s1_data;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (o_in_ready) begin
            n_s1_valid = i_in_valid;
            n_s1_data  = i_in_data;
        end
        if (out_free) begin
            n_out_valid = s1_take && emit;
            n_out_data  = pair_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        r_s1_data  <= n_s1_data;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/ryc_checker.sv
// Port-level checks for the RGB to YUYV 4:2:2 converter, bound to the top level.
// Depends on ryc_pkg and rgb_to_yuyv_422_converter_macros.svh.
`include "rgb_to_yuyv_422_converter_macros.svh"

module ryc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ryc_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ryc_pkg::t_out_word o_out_data
);

    // a stalled word holds
    `RYC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // input never stalls while the result register can move
    `RYC_ASSERT_NOW(a_in_ready_free, !o_out_valid || i_out_ready, o_in_ready)

    // first cycle after reset shows no word
    `RYC_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !o_out_valid)

endmodule

bind rgb_to_yuyv_422_converter ryc_checker u_ryc_checker (.*);

### test/tb.sv
// Testbench for rgb_to_yuyv_422_converter: drives RGB pixel rows, predicts YUYV words.
// Checks every output word field by field against a pair tracker model.
// Depends on ryc_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb;

    localparam int StallLimit = 4000;
    localparam int PhaseCount = 4;
    localparam int PhasePixels = 183;

    class yuyv_pair_tracker;
        ryc_pkg::t_out_word pending_words[$];
        ryc_pkg::t_in_word held_pixel;
        bit have_first = 1'b0;
        int pixels_seen = 0;
        int words_checked = 0;
        int pairs_closed = 0;
        int odd_ends = 0;
        int errors = 0;

        function int luma8(ryc_pkg::t_in_word px);
            return (77 * int'(px.red) + 150 * int'(px.green) + 29 * int'(px.blue)) >>> 8;
        endfunction

        function int cb8(ryc_pkg::t_in_word px);
            return (-43 * int'(px.red) - 84 * int'(px.green) + 127 * int'(px.blue)
                    + 32768) >>> 8;
        endfunction

        function int cr8(ryc_pkg::t_in_word px);
            return (127 * int'(px.red) - 106 * int'(px.green) - 21 * int'(px.blue)
                    + 32768) >>> 8;
        endfunction

        function ryc_pkg::t_out_word pair_word(ryc_pkg::t_in_word a, ryc_pkg::t_in_word b);
            ryc_pkg::t_out_word w;
            w.luma_first  = 8'(luma8(a));
            w.chroma_blue = 8'((cb8(a) + cb8(b)) >>> 1);
            w.luma_second = 8'(luma8(b));
            w.chroma_red  = 8'((cr8(a) + cr8(b)) >>> 1);
            return w;
        endfunction

        function void note_pixel(ryc_pkg::t_in_word px);
            pixels_seen++;
            if (have_first) begin
                pending_words.push_back(pair_word(held_pixel, px));
                have_first = 1'b0;
                pairs_closed++;
            end else if (px.last_in_row) begin
                pending_words.push_back(pair_word(px, px));
                odd_ends++;
            end else begin
                held_pixel = px;
                have_first = 1'b1;
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("word %0d: %s got %0d want %0d", words_checked, what, got, want);
            errors++;
        endtask

        task check_word(ryc_pkg::t_out_word w);
            ryc_pkg::t_out_word want;
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word, luma_first", w.luma_first, -1);
            end else begin
                want = pending_words.pop_front();
                if (w.luma_first !== want.luma_first)
                    report_mismatch("luma_first", w.luma_first, want.luma_first);
                if (w.chroma_blue !== want.chroma_blue)
                    report_mismatch("chroma_blue", w.chroma_blue, want.chroma_blue);
                if (w.luma_second !== want.luma_second)
                    report_mismatch("luma_second", w.luma_second, want.luma_second);
                if (w.chroma_red !== want.chroma_red)
                    report_mismatch("chroma_red", w.chroma_red, want.chroma_red);
            end
            words_checked++;
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    ryc_pkg::t_in_word  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    ryc_pkg::t_out_word o_out_data;

    yuyv_pair_tracker tracker;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;
    int phase_sent;

    rgb_to_yuyv_422_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready = 1'b0;
            hold_cycles--;
        end else begin
            i_out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_in_valid && o_in_ready) begin
                tracker.note_pixel(i_in_data);
                quiet_cycles = 0;
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_word(o_out_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= StallLimit) begin
                $display("timeout: %0d words still pending", tracker.pending_words.size());
                $display("rgb_to_yuyv_422_converter test failed");
                $finish;
            end
        end
    end

    task send_pixel(ryc_pkg::t_in_word px);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < send_idle_pct) begin
                i_in_valid = 1'b0;
            end else begin
                i_in_valid = 1'b1;
                i_in_data  = px;
                break;
            end
        end
        do @(posedge i_clk); while (!o_in_ready);
        phase_sent++;
    endtask

    task put_pixel(int r, int g, int b, bit last);
        ryc_pkg::t_in_word px;
        px.red = 8'(r);
        px.green = 8'(g);
        px.blue = 8'(b);
        px.last_in_row = last;
        send_pixel(px);
    endtask

    function logic [7:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task send_row(int width, bit noisy);
        bit last;
        for (int i = 0; i < width; i++) begin
            last = (i == width - 1);
            if (noisy && $urandom_range(0, 3) == 0)
                last = 1'($urandom_range(0, 1));
            put_pixel(rand_comp(), rand_comp(), rand_comp(), last);
        end
    endtask

    task drain_words();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int idle_plan[PhaseCount];
        int stall_plan[PhaseCount];
        idle_plan = '{0, 80, 0, 23};
        stall_plan = '{0, 0, 80, 23};
        tracker = new;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        phase_sent = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, odd row ends, pairs closing without a row end
        put_pixel(0, 0, 0, 1);
        put_pixel(255, 255, 255, 1);
        put_pixel(255, 0, 0, 0);
        put_pixel(0, 255, 0, 1);
        put_pixel(0, 0, 255, 0);
        put_pixel(255, 255, 0, 0);
        put_pixel(0, 255, 255, 0);
        put_pixel(255, 0, 255, 0);
        put_pixel(128, 128, 128, 1);
        put_pixel(255, 255, 255, 0);
        put_pixel(0, 0, 0, 1);
        put_pixel(0, 0, 255, 1);
        put_pixel(255, 0, 0, 1);
        put_pixel(0, 255, 0, 1);
        put_pixel(255, 255, 0, 1);
        put_pixel(1, 2, 4, 0);
        put_pixel(128, 64, 32, 1);
        drain_words();

        for (int p = 0; p < PhaseCount; p++) begin
            send_idle_pct = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            phase_sent = 0;
            if (p == 0)
                hold_cycles = 150;
            while (phase_sent < PhasePixels)
                send_row($urandom_range(1, 12), ($urandom_range(0, 6) == 0));
            // leave the last row closed so no pixel is held across phases
            put_pixel(rand_comp(), rand_comp(), rand_comp(), 1'b1);
            drain_words();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d pixels: %0d full pairs, %0d odd row ends, %0d words checked",
                 tracker.pixels_seen, tracker.pairs_closed, tracker.odd_ends,
                 tracker.words_checked);
        $display("idle mixes: none, sender 80%%, receiver 80%%, both 23%%, plus a long output hold");
        if (tracker.errors == 0) begin
            $display("rgb_to_yuyv_422_converter test passed");
        end else begin
            $display("%0d mismatches", tracker.errors);
            $display("rgb_to_yuyv_422_converter test failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ryc_pkg.sv
rtl/ryc_pix_calc.sv
rtl/ryc_pair.sv
rtl/rgb_to_yuyv_422_converter.sv
rtl/ryc_checker.sv
test/tb.sv
